// ===== hw/rtl/signed_int_to_decimal_ascii_assert.svh =====
// Assertion macros for the signed integer to decimal text converter.
// Used by the port checker; depends on nothing else.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SIDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sida: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sida: next-cycle check failed");

`endif

// ===== hw/rtl/sida_pkg.sv =====
// Shared constants and controller/datapath signal groups for the converter.
// No dependencies.
package sida_pkg;

   localparam int unsigned DIGIT_COUNT = 10;
   localparam int unsigned IDX_W       = $clog2(DIGIT_COUNT);
   localparam int unsigned CNT_W       = $clog2(DIGIT_COUNT + 1);

   localparam logic [7:0]  CHAR_ZERO   = 8'd48;
   localparam logic [7:0]  CHAR_MINUS  = 8'd45;
   localparam logic [31:0] RADIX       = 32'd10;
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   typedef struct packed {
      logic load;
      logic divide;
      logic pop;
      logic sign_sel;
   } sida_cmd_type;

   typedef struct packed {
      logic mag_small;
      logic negative;
      logic last_digit;
   } sida_sts_type;

endpackage

// ===== hw/rtl/sida_datapath.sv =====
// Datapath: magnitude register, reciprocal divide by ten, digit buffer and character select.
// Depends on sida_pkg.
module sida_datapath (
   input  logic                   clock,
   input  logic signed [31:0]     req_value,
   input  sida_pkg::sida_cmd_type cmd,
   output sida_pkg::sida_sts_type sts,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last
);

   localparam int unsigned QW = 64 - sida_pkg::RECIP_SHIFT;

   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [sida_pkg::CNT_W-1:0] cnt_ff, cnt_in, cnt_dec;
   logic [3:0]  digits_ff [sida_pkg::DIGIT_COUNT];
   logic [63:0] prod;
   logic [QW-1:0] quot;
   logic [31:0] quot_x10, rem_full;
   logic [31:0] value_u;
   logic [3:0]  rd_digit;

   assign value_u  = req_value;
   assign prod     = {32'b0, mag_ff} * {32'b0, sida_pkg::RECIP_TEN};
   assign quot     = prod[63:sida_pkg::RECIP_SHIFT];
   assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rem_full = mag_ff - quot_x10;
   assign cnt_dec  = cnt_ff - sida_pkg::CNT_W'(1);
   assign rd_digit = digits_ff[cnt_dec[sida_pkg::IDX_W-1:0]];

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         neg_in = value_u[31];
         mag_in = value_u[31] ? (~value_u + 32'd1) : value_u;
         cnt_in = '0;
      end else if (cmd.divide) begin
         mag_in = {{(32 - QW){1'b0}}, quot};
         cnt_in = cnt_ff + sida_pkg::CNT_W'(1);
      end else if (cmd.pop) begin
         cnt_in = cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (cmd.divide) begin
         digits_ff[cnt_ff[sida_pkg::IDX_W-1:0]] <= rem_full[3:0];
      end
   end

   assign sts.mag_small  = mag_ff < sida_pkg::RADIX;
   assign sts.negative   = neg_ff;
   assign sts.last_digit = cnt_ff == sida_pkg::CNT_W'(1);

   assign rsp_character = cmd.sign_sel ? sida_pkg::CHAR_MINUS
                                       : sida_pkg::CHAR_ZERO + {4'b0000, rd_digit};
   assign rsp_last      = !cmd.sign_sel && sts.last_digit;

endmodule

// ===== hw/rtl/sida_ctrl.sv =====
// Controller: sequences load, digit extraction, sign and digit output.
// Depends on sida_pkg.
module sida_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sida_pkg::sida_sts_type sts,
   output sida_pkg::sida_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.divide = 1'b1;
            if (sts.mag_small) begin
               state_in = sts.negative ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.sign_sel = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.pop = 1'b1;
               if (sts.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// Per value with D digits: one divide by ten per digit (one shared reciprocal multiplier),
// then one character per transaction (a minus sign if negative, then D digits), then back to idle.
// First character is valid once the divide steps are done; one value in flight at a time.
// Reset (synchronous, active high) returns the controller to idle; ready the next cycle.
module signed_int_to_decimal_ascii (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_character,
   output logic               rsp_last
);

   sida_pkg::sida_cmd_type cmd;
   sida_pkg::sida_sts_type sts;

   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sida_datapath u_datapath (
      .clock         (clock),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== hw/rtl/sida_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on signed_int_to_decimal_ascii_assert.svh and sida_pkg.
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_character,
   input logic       rsp_last
);

   logic req_take;
   logic rsp_take;
   logic rsp_done;
   logic char_ok;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign rsp_done = rsp_take && rsp_last;
   assign char_ok  = (rsp_character == sida_pkg::CHAR_MINUS && !rsp_last)
                  || (rsp_character >= sida_pkg::CHAR_ZERO
                      && rsp_character <= sida_pkg::CHAR_ZERO + 8'd9);

   `SIDA_ASSERT_NOW(a_busy_while_output, clock, reset, rsp_valid, req_stall)
   `SIDA_ASSERT_NEXT(a_divide_after_take, clock, reset, req_take, !rsp_valid)
   `SIDA_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_done, !rsp_valid && !req_stall)
   `SIDA_ASSERT_NOW(a_legal_character, clock, reset, rsp_valid, char_ok)
   `SIDA_ASSERT_NEXT(a_stalled_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_character, rsp_last}))

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

// ===== bench/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking bench for the signed integer to decimal text converter.
// Drives signed 32-bit values, predicts each character run and checks it field by field.
// Depends on sida_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SETTLE_TIME  = 40;
   localparam int unsigned RANDOM_ITEMS = 212;

   typedef struct packed {
      logic [7:0] code;
      logic       is_last;
   } text_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_character;
   logic               rsp_last;

   logic [31:0]    pending_values[$];
   text_char_type  expected_text[$];
   logic           req_taken = 1'b0;
   int unsigned    req_gap = 0;
   int unsigned    rsp_hold = 0;
   int unsigned    mode_left = 0;
   logic           req_quiet = 1'b0;
   logic           rsp_quiet = 1'b0;
   int unsigned    idle_cycles = 0;
   int unsigned    error_count = 0;

   int edge_values [18] = '{0, 1, -1, 9, 10, -9, -10, 99, 100, -100, 12345, -67890,
                           999999999, 1000000000, -1000000000, 2147483647, -2147483647,
                           32'h8000_0000};

   signed_int_to_decimal_ascii i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic int unsigned idle_length(input logic quiet);
      int unsigned pick;
      pick = $urandom_range(99);
      if (quiet || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic push_decimal_text(input logic [31:0] number);
      logic [32:0]    magnitude;
      logic [3:0]     digits[$];
      text_char_type  next_char;
      magnitude = number[31] ? (33'h1_0000_0000 - {1'b0, number}) : {1'b0, number};
      do begin
         digits.push_back(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (number[31]) begin
         next_char.code    = sida_pkg::CHAR_MINUS;
         next_char.is_last = 1'b0;
         expected_text.push_back(next_char);
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
         next_char.code    = sida_pkg::CHAR_ZERO + 8'(digits[k]);
         next_char.is_last = (k == 0);
         expected_text.push_back(next_char);
      end
   endtask

   // pick burst phases so both sides see quiet stretches as well as gaps
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left <= $urandom_range(50, 300);
         req_quiet <= ($urandom_range(3) == 0);
         rsp_quiet <= ($urandom_range(3) == 0);
      end else begin
         mode_left <= mode_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_values.size() > 0) begin
            req_valid <= 1'b1;
            req_value <= pending_values.pop_front();
            req_gap   <= idle_length(req_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else if (!rsp_quiet && $urandom_range(3) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= idle_length(1'b0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) push_decimal_text(req_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("rsp_character: no character expected, got %0d", rsp_character);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.code) begin
                  $error("rsp_character: expected %0d, got %0d", want.code, rsp_character);
                  error_count++;
               end
               if (rsp_last !== want.is_last) begin
                  $error("rsp_last: expected %0b, got %0b", want.is_last, rsp_last);
                  error_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned     band;
      int unsigned     digit_count;
      longint unsigned low_bound;
      longint unsigned high_bound;
      longint unsigned magnitude;
      logic            negative;
      foreach (edge_values[i]) pending_values.push_back(edge_values[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         band     = $urandom_range(9);
         negative = 1'($urandom_range(1));
         if (band < 3) begin
            pending_values.push_back($urandom());
         end else begin
            if (band == 9) begin
               low_bound  = 0;
               high_bound = 20;
            end else begin
               digit_count = $urandom_range(1, 10);
               low_bound   = 1;
               for (int d = 1; d < digit_count; d++) low_bound = low_bound * 10;
               high_bound = (digit_count == 10) ? (negative ? 64'd2147483648 : 64'd2147483647)
                                                : low_bound * 10 - 1;
               if (digit_count == 1) low_bound = 0;
            end
            magnitude = 64'($urandom_range(32'(high_bound), 32'(low_bound)));
            pending_values.push_back(negative ? 32'(-magnitude) : 32'(magnitude));
         end
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_values.size() > 0 || req_valid || expected_text.size() > 0)
         @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
+incdir+hw/rtl
hw/rtl/sida_pkg.sv
hw/rtl/sida_datapath.sv
hw/rtl/sida_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii.sv
hw/rtl/sida_checker.sv
bench/signed_int_to_decimal_ascii_tb.sv
